// File: src/bole_pkg.sv
package bole_pkg;

  // Default list capacity and fixed field widths.
  localparam int DEPTH_DEF = 16;
  localparam int CMD_W     = 3;
  localparam int POS_W     = 8;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int LEN_W     = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_TAIL = 3'd0,
    CMD_INS_POS  = 3'd1,
    CMD_INS_HEAD = 3'd2,
    CMD_DEL_POS  = 3'd3,
    CMD_DEL_HEAD = 3'd4,
    CMD_READ     = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic op_do;     // apply a single-result command and load its result
    logic elem_emit; // emit the head cell, rotate the row, advance the read count
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;   // output register can take a new beat this cycle
    logic count_zero; // list holds no element
    logic emit_last;  // the next element emitted is the final one
  } dp_stat_t;

endpackage

// File: src/bole_ctrl.sv
module bole_ctrl
  import bole_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] cmd,
  input  dp_stat_t         stat,
  output logic             in_stall,
  output ctrl_cmd_t        ctl
);

  state_t state;
  state_t state_next;
  logic   accept;
  logic   read_stream;

  assign accept      = in_valid && stat.out_free && (state == S_IDLE);
  assign read_stream = (cmd == CMD_READ) && !stat.count_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && read_stream && !stat.emit_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (stat.out_free && stat.emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    ctl.op_do     = 1'b0;
    ctl.elem_emit = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall      = !stat.out_free;
        ctl.op_do     = accept && !read_stream;
        ctl.elem_emit = accept && read_stream;
      end
      S_READ: begin
        ctl.elem_emit = stat.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: src/bole_dp.sv
module bole_dp
  import bole_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [POS_W-1:0]  position,
  input  logic signed [VAL_W-1:0] item_value,
  input  ctrl_cmd_t         ctl,
  output dp_stat_t          stat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic signed [VAL_W-1:0] element_value,
  output logic [LEN_W-1:0]  element_index,
  output logic [LEN_W-1:0]  list_length,
  output logic              last
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VAL_W-1:0] cells      [DEPTH];
  logic [VAL_W-1:0] cells_next [DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] count_m1;
  logic [CNT_W-1:0] rd_cnt;
  logic [CNT_W-1:0] rd_inc;

  logic             full;
  logic             empty;
  logic [POS_W-1:0] count_p;
  logic [POS_W-1:0] pos_m1;
  logic [POS_W-1:0] slot_p;
  logic [IDX_W-1:0] slot;
  logic             do_ins;
  logic             do_del;
  logic             wr_ins;
  logic             wr_del;
  status_t          st;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign count_p  = POS_W'(count);
  assign pos_m1   = position - POS_W'(1);
  assign count_m1 = count - CNT_W'(1);
  assign rd_inc   = rd_cnt + CNT_W'(1);

  // Command decode: status, and where the row opens or closes.
  always_comb begin
    st     = STAT_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    slot_p = '0;
    case (cmd)
      CMD_INS_TAIL: begin
        slot_p = count_p;
        if (full) st = STAT_FULL;
        else      do_ins = 1'b1;
      end
      CMD_INS_POS: begin
        slot_p = (position == '0) ? '0 : pos_m1;
        if (full)                 st = STAT_FULL;
        else if (slot_p > count_p) st = STAT_INVALID;
        else                      do_ins = 1'b1;
      end
      CMD_INS_HEAD: begin
        if (full) st = STAT_FULL;
        else      do_ins = 1'b1;
      end
      CMD_DEL_POS: begin
        slot_p = pos_m1;
        if (empty)                  st = STAT_EMPTY;
        else if (position == '0)    st = STAT_INVALID;
        else if (pos_m1 >= count_p) st = STAT_INVALID;
        else                        do_del = 1'b1;
      end
      CMD_DEL_HEAD: begin
        if (empty) st = STAT_EMPTY;
        else       do_del = 1'b1;
      end
      CMD_READ: begin
        if (empty) st = STAT_EMPTY;
      end
      default: begin
        st = STAT_OK;
      end
    endcase
  end

  assign slot   = slot_p[IDX_W-1:0];
  assign wr_ins = ctl.op_do && do_ins;
  assign wr_del = ctl.op_do && do_del;

  always_comb begin
    count_next = count;
    if (wr_ins)      count_next = count + CNT_W'(1);
    else if (wr_del) count_next = count_m1;
  end

  // Each cell sees only itself, its two neighbours and the head cell.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] prev_c;
    logic [VAL_W-1:0] next_c;
    if (g == 0) begin : g_first
      assign prev_c = cells[0];
    end else begin : g_mid
      assign prev_c = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_c = cells[g];
    end else begin : g_body
      assign next_c = cells[g+1];
    end
    always_comb begin
      cells_next[g] = cells[g];
      if (wr_ins) begin
        if (IDX_W'(g) == slot)     cells_next[g] = item_value;
        else if (IDX_W'(g) > slot) cells_next[g] = prev_c;
      end else if (wr_del) begin
        if (IDX_W'(g) >= slot) cells_next[g] = next_c;
      end else if (ctl.elem_emit) begin
        // Rotate the occupied part so the head wraps to the tail.
        cells_next[g] = (CNT_W'(g) == count_m1) ? cells[0] : next_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_cnt <= '0;
    end else begin
      count <= count_next;
      if (ctl.elem_emit) begin
        rd_cnt <= stat.emit_last ? '0 : rd_inc;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.op_do || ctl.elem_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.elem_emit) begin
      status        <= STAT_OK;
      element_value <= cells[0];
      element_index <= LEN_W'(rd_inc);
      list_length   <= LEN_W'(count);
      last          <= stat.emit_last;
    end else if (ctl.op_do) begin
      status        <= st;
      element_value <= '0;
      element_index <= '0;
      list_length   <= LEN_W'(count_next);
      last          <= 1'b1;
    end
  end

  assign stat.out_free   = !out_valid || !out_stall;
  assign stat.count_zero = empty;
  assign stat.emit_last  = (rd_inc == count);

endmodule

// File: src/bounded_ordered_list_engine_core.sv
// Channel | Direction | Handshake            | Fields
// input   | in        | in_valid / in_stall  | cmd, position, item_value
// output  | out       | out_valid / out_stall| status, element_value, element_index,
//         |           |                      | list_length, last
//
// A command other than read out yields one beat.
// Read out of n elements yields n beats, one a cycle unless the output stalls,
// and the next command is taken only after the last of them; the single rotating cell row sets this.
// Reset is synchronous and active high; it empties the list and the output register.
// Cell contents are not cleared by reset; only occupied cells are ever read.
// A stall on the output holds the current beat and stalls the input side too.
module bounded_ordered_list_engine_core
  import bole_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [POS_W-1:0]  position,
  input  logic signed [VAL_W-1:0] item_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic signed [VAL_W-1:0] element_value,
  output logic [LEN_W-1:0]  element_index,
  output logic [LEN_W-1:0]  list_length,
  output logic              last
);

  // The controller decides when a beat is accepted and whether a command
  // streams; the datapath holds the cell row, the count and the output register.
  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  bole_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .stat     (stat),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  // Inserts and deletes shift the row in place. Read out
  // rotates the occupied cells once per beat, so after the last beat the
  // list is back in its original order.
  bole_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .position      (position),
    .item_value    (item_value),
    .ctl           (ctl),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .element_value (element_value),
    .element_index (element_index),
    .list_length   (list_length),
    .last          (last)
  );

endmodule

// File: src/bole_chk.sv
module bole_chk
  import bole_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STAT_W-1:0] status,
  input logic [VAL_W-1:0]  element_value,
  input logic [LEN_W-1:0]  element_index,
  input logic [LEN_W-1:0]  list_length,
  input logic              last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(element_value)
      && $stable(element_index) && $stable(list_length) && $stable(last))
    else $error("stalled output beat changed");

  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> list_length <= LEN_W'(DEPTH))
    else $error("list length beyond capacity");

  a_elem: assert property (@(posedge clk) disable iff (rst)
    out_valid && element_index != '0 |->
      status == STAT_OK && element_index <= list_length)
    else $error("element beat with bad status or index");

  a_notlast: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> element_index != '0 && element_index < list_length)
    else $error("non-final beat outside read out");

  a_backp: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

endmodule

bind bounded_ordered_list_engine_core bole_chk #(.DEPTH(DEPTH)) u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .element_value (element_value),
  .element_index (element_index),
  .list_length   (list_length),
  .last          (last)
);

// File: verif/tb.sv
module tb;
  import bole_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;

  // The block gives no meaning to these two command codes; it must leave the
  // list alone and answer with a single OK beat.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // Cycles allowed for the final beat to drain after the last expectation has
  // been met, and a hard ceiling on the whole run in time units.
  localparam int DRAIN_CYCLES = 20;
  localparam int RUN_CEILING  = 5_000_000;
  localparam int ITEMS_PER_PHASE = 134;

  typedef struct {
    logic [CMD_W-1:0]        op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
  } list_cmd_t;

  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] value;
    logic [LEN_W-1:0]        index;
    logic [LEN_W-1:0]        length;
    logic                    last;
  } list_beat_t;

  // Every input starts at a known value so that nothing floats into the
  // block before reset has even been seen.
  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    in_valid   = 1'b0;
  logic                    in_stall;
  logic [CMD_W-1:0]        cmd        = '0;
  logic [POS_W-1:0]        position   = '0;
  logic signed [VAL_W-1:0] item_value = '0;
  logic                    out_valid;
  logic                    out_stall  = 1'b0;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] element_value;
  logic [LEN_W-1:0]        element_index;
  logic [LEN_W-1:0]        list_length;
  logic                    last;

  bounded_ordered_list_engine_core #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .position     (position),
    .item_value   (item_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .element_value(element_value),
    .element_index(element_index),
    .list_length  (list_length),
    .last         (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Commands waiting to be offered to the block, and the beats that the
  // block still owes us, oldest first.
  list_cmd_t  pending_cmds[$];
  list_beat_t expected_beats[$];

  // Our own copy of the list, updated as each command is accepted.
  logic signed [VAL_W-1:0] cells [LIST_DEPTH];
  int cell_count = 0;

  // Length that the stimulus planner believes the list will have once every
  // command queued so far has been applied; it steers positions towards
  // sensible values. grow_list says whether the planner is currently
  // filling or draining the list.
  int planned_len = 0;
  bit grow_list = 1'b1;

  int send_idle_pct = 37;
  int recv_idle_pct = 81;
  int mismatches = 0;
  logic in_fire = 1'b0;

  logic signed [VAL_W-1:0] corner_vals [4] = '{32'sh7fffffff, 32'sh80000000, '0, '1};
  cmd_t insert_ops [3] = '{CMD_INS_TAIL, CMD_INS_POS, CMD_INS_HEAD};

  task automatic add_beat(input status_t st, input logic signed [VAL_W-1:0] val,
                          input int idx, input logic lst);
    list_beat_t b;
    b.status = st;
    b.value  = val;
    b.index  = LEN_W'(idx);
    b.length = LEN_W'(cell_count);
    b.last   = lst;
    expected_beats.push_back(b);
  endtask

  // Applies one accepted command to our copy of the list and queues the
  // beats it should produce. Fullness is judged before the position, and an
  // empty list is judged before a bad delete position.
  task automatic predict_list_op(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                                 input logic signed [VAL_W-1:0] v);
    status_t st;
    int slot;
    st = STAT_OK;
    case (c)
      CMD_INS_TAIL, CMD_INS_POS, CMD_INS_HEAD: begin
        if (c == CMD_INS_TAIL) slot = cell_count;
        else if (c == CMD_INS_HEAD || p == 0) slot = 0;
        else slot = int'(p) - 1;
        if (cell_count >= LIST_DEPTH) begin
          st = STAT_FULL;
        end else if (slot > cell_count) begin
          st = STAT_INVALID;
        end else begin
          for (int i = cell_count; i > slot; i--) cells[i] = cells[i-1];
          cells[slot] = v;
          cell_count++;
        end
      end
      CMD_DEL_POS, CMD_DEL_HEAD: begin
        slot = (c == CMD_DEL_HEAD) ? 0 : int'(p) - 1;
        if (cell_count == 0) begin
          st = STAT_EMPTY;
        end else if (slot < 0 || slot >= cell_count) begin
          st = STAT_INVALID;
        end else begin
          for (int i = slot; i + 1 < cell_count; i++) cells[i] = cells[i+1];
          cell_count--;
        end
      end
      CMD_READ: begin
        if (cell_count == 0) begin
          add_beat(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < cell_count; i++)
            add_beat(STAT_OK, cells[i], i + 1, (i + 1 == cell_count));
        end
        return;
      end
      default: ;
    endcase
    add_beat(st, '0, 0, 1'b1);
  endtask

  // Queues a command for the driver and tracks the length it should leave.
  task automatic queue_command(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                               input logic signed [VAL_W-1:0] v);
    list_cmd_t it;
    it.op  = c;
    it.pos = p;
    it.val = v;
    pending_cmds.push_back(it);
    case (c)
      CMD_INS_TAIL, CMD_INS_HEAD: if (planned_len < LIST_DEPTH) planned_len++;
      CMD_INS_POS: if (planned_len < LIST_DEPTH && int'(p) <= planned_len + 1) planned_len++;
      CMD_DEL_POS: if (p >= 1 && int'(p) <= planned_len) planned_len--;
      CMD_DEL_HEAD: if (planned_len > 0) planned_len--;
      default: ;
    endcase
  endtask

  // Random commands. Most are inserts and deletes at positions that the list
  // can take, so that it swings between empty and full; the planner dwells
  // at either end for a while so that full inserts and empty deletes occur.
  // A tenth of positions are drawn from the whole field, and a slice of the
  // commands is pure noise including the unused codes.
  task automatic plan_random(input int count);
    int r;
    bit wild;
    logic [CMD_W-1:0] c;
    logic [POS_W-1:0] p;
    logic signed [VAL_W-1:0] v;
    for (int k = 0; k < count; k++) begin
      if (planned_len == LIST_DEPTH && $urandom_range(2) == 0) grow_list = 1'b0;
      else if (planned_len == 0 && $urandom_range(2) == 0) grow_list = 1'b1;
      else if ($urandom_range(19) == 0) grow_list = !grow_list;
      r    = $urandom_range(99);
      wild = ($urandom_range(9) == 0);
      v    = ($urandom_range(7) == 0) ? corner_vals[$urandom_range(3)] : $urandom;
      p    = POS_W'($urandom_range(255));
      if (r < 4) begin
        c = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      end else if (r < 8) begin
        c = CMD_W'($urandom_range(7));
      end else if (r < 18) begin
        c = CMD_READ;
      end else if ($urandom_range(99) < (grow_list ? 70 : 30)) begin
        c = insert_ops[$urandom_range(2)];
        if (!wild) p = POS_W'($urandom_range(planned_len + 1));
      end else begin
        c = $urandom_range(1) ? CMD_DEL_POS : CMD_DEL_HEAD;
        if (!wild) p = POS_W'($urandom_range(planned_len, 1));
      end
      queue_command(c, p, v);
    end
  endtask

  // Driver: a new beat is offered only once the previous one has gone in,
  // so a stalled payload stays put. The sender idles at random, never in
  // response to the stall, and the receiver stalls at random every cycle.
  always @(negedge clk) begin : drive
    list_cmd_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_cmds.pop_front();
        cmd        <= it.op;
        position   <= it.pos;
        item_value <= it.val;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: on each rising edge an accepted command is run through our
  // list, then an accepted output beat is held against the oldest
  // expectation, field by field.
  always @(posedge clk) begin : watch
    list_beat_t want;
    in_fire <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) predict_list_op(cmd, position, item_value);
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("output beat with nothing expected: status %0d, value %0d, index %0d",
               status, element_value, element_index);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (element_value !== want.value) begin
          $error("element_value: expected %0d, got %0d", want.value, element_value);
          mismatches++;
        end
        if (element_index !== want.index) begin
          $error("element_index: expected %0d, got %0d", want.index, element_index);
          mismatches++;
        end
        if (list_length !== want.length) begin
          $error("list_length: expected %0d, got %0d", want.length, list_length);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          mismatches++;
        end
      end
    end
  end

  int sender_idle_by_phase [3] = '{37, 81, 0};
  int receiver_idle_by_phase [3] = '{81, 37, 0};

  initial begin
    // Directed opening. Read and both deletes on an empty list, with an empty list
    // taking precedence over a bad delete position, and an insert past the
    // end of an empty list.
    queue_command(CMD_READ, '0, '0);
    queue_command(CMD_DEL_HEAD, '0, '0);
    queue_command(CMD_DEL_POS, 8'd0, '0);
    queue_command(CMD_INS_POS, 8'd2, 32'sd5);
    // Fill to capacity with every kind of insert: at the tail, at position
    // zero and one (both mean the head), in the middle, at length plus one,
    // and at the head. Corner values go in alongside random ones.
    for (int n = 0; n < LIST_DEPTH; n++) begin
      logic signed [VAL_W-1:0] v;
      v = (n % 2) ? $urandom : corner_vals[(n / 4) % 4];
      case (n % 4)
        0: queue_command(CMD_INS_TAIL, 8'd255, v);
        1: queue_command(CMD_INS_POS, (n == 1) ? 8'd0 : (n == 5) ? 8'd1 :
                         POS_W'(planned_len / 2 + 1), v);
        2: queue_command(CMD_INS_POS, POS_W'(planned_len + 1), v);
        default: queue_command(CMD_INS_HEAD, '0, v);
      endcase
    end
    // A full list refuses an insert before it looks at the position.
    queue_command(CMD_INS_POS, 8'd255, 32'sd1);
    queue_command(CMD_READ, '0, '0);
    // Deletes at position zero and past the end fail; the tail, the head and
    // a middle element then go.
    queue_command(CMD_DEL_POS, 8'd0, '0);
    queue_command(CMD_DEL_POS, POS_W'(LIST_DEPTH + 1), '0);
    queue_command(CMD_DEL_POS, POS_W'(LIST_DEPTH), '0);
    queue_command(CMD_DEL_POS, 8'd1, '0);
    queue_command(CMD_DEL_POS, 8'd7, '0);
    queue_command(CMD_SPARE_LO, 8'd3, 32'sd9);
    queue_command(CMD_SPARE_HI, 8'd255, '1);
    queue_command(CMD_READ, '0, '0);

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Three idling regimes: a reluctant receiver, a reluctant sender, and
    // finally both flat out. Each phase drains its commands before the next.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = sender_idle_by_phase[ph];
      recv_idle_pct = receiver_idle_by_phase[ph];
      plan_random(ITEMS_PER_PHASE);
      while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    end

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Watchdog: a beat that never arrives ends the run here.
  initial begin
    #RUN_CEILING;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
src/bole_pkg.sv
src/bole_ctrl.sv
src/bole_dp.sv
src/bounded_ordered_list_engine_core.sv
src/bole_chk.sv
verif/tb.sv
